### rtl/dual_overwriting_retention_queue_core_defines.svh
// Assertion macros shared by the queue core.
`ifndef DUAL_OVERWRITING_RETENTION_QUEUE_CORE_DEFINES_SVH
`define DUAL_OVERWRITING_RETENTION_QUEUE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DORQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DORQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dorq_pkg.sv
package dorq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int DIFF_W        = CNT_W + 1;

    // Shared entry memory: both queues, queue select is the address MSB
    localparam int MEM_AW        = PTR_W + 1;
    localparam int MEM_DEPTH     = 2 ** MEM_AW;
    localparam int ENTRY_W       = PAYLOAD_WIDTH + 40;

    // Port field widths
    localparam int MODE_W        = 3;
    localparam int PORT_PAY_W    = 64;
    localparam int ALERT_W       = 8;
    localparam int TIME_W        = 32;
    localparam int FILL_W        = 5;
    localparam int LOSS_W        = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_ROUTINE   = 3'd0,
        MODE_PUSH_ALERT     = 3'd1,
        MODE_PEEK_ALERT     = 3'd2,
        MODE_PEEK_ROUTINE   = 3'd3,
        MODE_COMMIT_ALERT   = 3'd4,
        MODE_COMMIT_ROUTINE = 3'd5
    } t_mode;

    typedef struct packed {
        logic [FILL_W-1:0] alert_fill;
        logic [FILL_W-1:0] routine_fill;
        logic [LOSS_W-1:0] alert_losses;
        logic [LOSS_W-1:0] routine_losses;
        logic              pending;
    } t_status;

endpackage

### rtl/dorq_ifs.sv
// Request channel: one queue operation per request.
interface dorq_req_if;
    import dorq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [PORT_PAY_W-1:0] payload;
    logic [ALERT_W-1:0]    alert_flags;
    logic [TIME_W-1:0]     timestamp;

    modport source (output valid, mode, payload, alert_flags, timestamp, input ready);
    modport sink   (input valid, mode, payload, alert_flags, timestamp, output ready);
endinterface

// Response channel: one status/entry record per request.
interface dorq_rsp_if;
    import dorq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [PORT_PAY_W-1:0] entry_payload;
    logic [ALERT_W-1:0]    entry_alerts;
    logic [TIME_W-1:0]     entry_time;
    logic [FILL_W-1:0]     alert_fill;
    logic [FILL_W-1:0]     routine_fill;
    logic [LOSS_W-1:0]     alert_losses;
    logic [LOSS_W-1:0]     routine_losses;
    logic                  pending;

    modport source (output valid, found, entry_payload, entry_alerts, entry_time,
                    alert_fill, routine_fill, alert_losses, routine_losses, pending,
                    input ready);
    modport sink   (input valid, found, entry_payload, entry_alerts, entry_time,
                    alert_fill, routine_fill, alert_losses, routine_losses, pending,
                    output ready);
endinterface

### rtl/dorq_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module dorq_ram #(
    parameter int   DEPTH = 32,
    parameter int   WIDTH = 8,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/dual_overwriting_retention_queue_core.sv
// Two overwriting ring queues (routine and alert) sharing one entry RAM.
// i_req carries one operation per request: push routine/alert, peek
// alert/routine, commit alert/routine (other mode codes report status only).
// A push stores payload, alert flags and timestamp at the head; on a full
// queue it overwrites the oldest entry and bumps that queue's 16-bit drop
// counter. A peek reads the oldest entry without removing it; a commit
// drops it. o_rsp returns exactly one record per request: peek data (zero
// unless found) plus both fill levels, both drop counters and pending.
// The response passes through the middle stage (RAM read) and the output
// register. Throughput: one request per cycle while o_rsp is not stalled;
// pointers and counters update in the accept cycle, so each RAM read and
// write touches a settled address. A stalled receiver holds the output
// register; one more request is then taken into the middle stage before
// i_req.ready drops.
// Reset (synchronous, active low) empties both queues and clears the drop
// counters; the RAM is not cleared since only written entries are read.
`include "dual_overwriting_retention_queue_core_defines.svh"

module dual_overwriting_retention_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dorq_req_if.sink    i_req,
    dorq_rsp_if.source  o_rsp
);
    import dorq_pkg::*;

    // queue state
    logic [PTR_W-1:0]   r_rt_wptr, n_rt_wptr, r_al_wptr, n_al_wptr;
    logic [CNT_W-1:0]   r_rt_cnt, n_rt_cnt, r_al_cnt, n_al_cnt;
    logic [LOSS_W-1:0]  r_rt_drops, n_rt_drops, r_al_drops, n_al_drops;

    // request decode
    logic               acc;
    t_mode              mode;
    logic               sel_alert, is_push, is_peek, is_commit;
    logic               full;
    logic [PTR_W-1:0]   cur_wptr, nxt_wptr, old_idx;
    logic [CNT_W-1:0]   cur_cnt, nxt_cnt;
    logic [LOSS_W-1:0]  cur_drops, nxt_drops;
    logic [DIFF_W-1:0]  diff;

    // RAM port
    logic               mem_wr_en, mem_rd_en;
    logic [MEM_AW-1:0]  wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;

    // middle stage and output register
    logic               r_s1_valid, r_s1_found;
    t_status            r_s1_status, n_status;
    logic               r_out_valid, r_out_found;
    logic [PORT_PAY_W-1:0] r_out_payload;
    logic [ALERT_W-1:0] r_out_alerts;
    logic [TIME_W-1:0]  r_out_time;
    t_status            r_out_status;
    logic               s1_adv, req_ready;

    assign acc = i_req.valid && req_ready;

    // mode decode
    always_comb begin
        mode      = t_mode'(i_req.mode);
        sel_alert = 1'b0;
        is_push   = 1'b0;
        is_peek   = 1'b0;
        is_commit = 1'b0;
        case (mode)
            MODE_PUSH_ROUTINE:   is_push = 1'b1;
            MODE_PUSH_ALERT: begin
                is_push   = 1'b1;
                sel_alert = 1'b1;
            end
            MODE_PEEK_ALERT: begin
                is_peek   = 1'b1;
                sel_alert = 1'b1;
            end
            MODE_PEEK_ROUTINE:   is_peek = 1'b1;
            MODE_COMMIT_ALERT: begin
                is_commit = 1'b1;
                sel_alert = 1'b1;
            end
            MODE_COMMIT_ROUTINE: is_commit = 1'b1;
            default: ;
        endcase
    end

    // selected queue, next pointer/count/drops, oldest index
    always_comb begin
        cur_wptr  = sel_alert ? r_al_wptr  : r_rt_wptr;
        cur_cnt   = sel_alert ? r_al_cnt   : r_rt_cnt;
        cur_drops = sel_alert ? r_al_drops : r_rt_drops;
        full      = (cur_cnt == CNT_W'(QUEUE_DEPTH));

        nxt_wptr  = cur_wptr;
        nxt_cnt   = cur_cnt;
        nxt_drops = cur_drops;
        if (is_push) begin
            nxt_wptr = (cur_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_wptr + 1'b1;
            if (full) begin
                nxt_drops = cur_drops + 1'b1;
            end else begin
                nxt_cnt = cur_cnt + 1'b1;
            end
        end
        if (is_commit && (cur_cnt != '0)) begin
            nxt_cnt = cur_cnt - 1'b1;
        end

        // oldest = (wptr - cnt) mod depth
        diff    = DIFF_W'(cur_wptr) - DIFF_W'(cur_cnt);
        old_idx = diff[DIFF_W-1] ? PTR_W'(diff + DIFF_W'(QUEUE_DEPTH)) : PTR_W'(diff);
    end

    // state next values
    always_comb begin
        n_rt_wptr  = r_rt_wptr;
        n_rt_cnt   = r_rt_cnt;
        n_rt_drops = r_rt_drops;
        n_al_wptr  = r_al_wptr;
        n_al_cnt   = r_al_cnt;
        n_al_drops = r_al_drops;
        if (acc) begin
            if (sel_alert) begin
                n_al_wptr  = nxt_wptr;
                n_al_cnt   = nxt_cnt;
                n_al_drops = nxt_drops;
            end else begin
                n_rt_wptr  = nxt_wptr;
                n_rt_cnt   = nxt_cnt;
                n_rt_drops = nxt_drops;
            end
        end
        n_status.alert_fill     = FILL_W'(n_al_cnt);
        n_status.routine_fill   = FILL_W'(n_rt_cnt);
        n_status.alert_losses   = n_al_drops;
        n_status.routine_losses = n_rt_drops;
        n_status.pending        = (n_al_cnt != '0) || (n_rt_cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_wptr  <= '0;
            r_rt_cnt   <= '0;
            r_rt_drops <= '0;
            r_al_wptr  <= '0;
            r_al_cnt   <= '0;
            r_al_drops <= '0;
        end else begin
            r_rt_wptr  <= n_rt_wptr;
            r_rt_cnt   <= n_rt_cnt;
            r_rt_drops <= n_rt_drops;
            r_al_wptr  <= n_al_wptr;
            r_al_cnt   <= n_al_cnt;
            r_al_drops <= n_al_drops;
        end
    end

    // entry RAM: push writes at the head, peek reads the oldest
    assign mem_wr_en = acc && is_push;
    assign wr_addr   = {sel_alert, cur_wptr};
    assign wr_data   = {i_req.alert_flags, i_req.timestamp,
                        i_req.payload[PAYLOAD_WIDTH-1:0]};
    assign mem_rd_en = acc && is_peek;
    assign rd_addr   = {sel_alert, old_idx};

    dorq_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // handshake between stages
    assign s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign req_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_found  <= is_peek && (cur_cnt != '0);
            r_s1_status <= n_status;
        end
        if (s1_adv) begin
            r_out_found   <= r_s1_found;
            r_out_payload <= r_s1_found ? PORT_PAY_W'(rd_data[PAYLOAD_WIDTH-1:0]) : '0;
            r_out_alerts  <= r_s1_found ? rd_data[ENTRY_W-1 -: ALERT_W] : '0;
            r_out_time    <= r_s1_found ? rd_data[PAYLOAD_WIDTH +: TIME_W] : '0;
            r_out_status  <= r_s1_status;
        end
    end

    assign i_req.ready          = req_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.found          = r_out_found;
    assign o_rsp.entry_payload  = r_out_payload;
    assign o_rsp.entry_alerts   = r_out_alerts;
    assign o_rsp.entry_time     = r_out_time;
    assign o_rsp.alert_fill     = r_out_status.alert_fill;
    assign o_rsp.routine_fill   = r_out_status.routine_fill;
    assign o_rsp.alert_losses   = r_out_status.alert_losses;
    assign o_rsp.routine_losses = r_out_status.routine_losses;
    assign o_rsp.pending        = r_out_status.pending;

    // checks
    `DORQ_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, (r_rt_cnt <= CNT_W'(QUEUE_DEPTH)) && (r_al_cnt <= CNT_W'(QUEUE_DEPTH)), "queue fill above depth")
    `DORQ_ASSERT_NEXT(a_rt_drop, i_clk, i_rst_n, acc && is_push && full && !sel_alert, r_rt_drops == LOSS_W'($past(r_rt_drops) + 1'b1), "routine overwrite not counted")
    `DORQ_ASSERT_NEXT(a_al_drop, i_clk, i_rst_n, acc && is_push && full && sel_alert, r_al_drops == LOSS_W'($past(r_al_drops) + 1'b1), "alert overwrite not counted")
    `DORQ_ASSERT_NEXT(a_peek_hit, i_clk, i_rst_n, acc && is_peek && (cur_cnt != '0), r_s1_valid && r_s1_found, "peek on filled queue lost")

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dorq_pkg::*;

    // Mode codes outside the package enum; the block reports status only
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    localparam int ROUTINE_Q     = 0;
    localparam int ALERT_Q       = 1;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int FLAT_PUSHES   = QUEUE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SHOWN_ERRORS  = 10;
    localparam logic [63:0] PAY_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - PAYLOAD_WIDTH);

    typedef struct packed {
        logic                  found;
        logic [PORT_PAY_W-1:0] payload;
        logic [ALERT_W-1:0]    alerts;
        logic [TIME_W-1:0]     tstamp;
        logic [FILL_W-1:0]     alert_fill;
        logic [FILL_W-1:0]     routine_fill;
        logic [LOSS_W-1:0]     alert_losses;
        logic [LOSS_W-1:0]     routine_losses;
        logic                  pending;
    } t_queue_reply;

    logic i_clk;
    logic i_rst_n;

    dorq_req_if req_ch ();
    dorq_rsp_if rsp_ch ();

    dual_overwriting_retention_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of both ring queues
    logic [PORT_PAY_W-1:0] q_pay    [2][QUEUE_DEPTH];
    logic [ALERT_W-1:0]    q_alerts [2][QUEUE_DEPTH];
    logic [TIME_W-1:0]     q_tstamp [2][QUEUE_DEPTH];
    logic [PTR_W-1:0]      q_wptr   [2];
    logic [CNT_W-1:0]      q_fill   [2];
    logic [LOSS_W-1:0]     q_losses [2];

    t_queue_reply expected_replies[$];

    int mismatches;
    int n_requests;
    int n_replies;
    int n_overwrites;
    int n_peek_hits;
    int n_peek_misses;
    int n_idle_commits;

    // Sender burst/gap control and receiver stall pattern
    bit          tx_idle_on;
    int          burst_left;
    bit          rx_stall_on;
    logic [15:0] rx_mask;
    int          rx_phase;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("testbench: FAIL");
        $finish;
    end

    // Applies one request to the shadow queues and returns the reply it should get
    function automatic t_queue_reply apply_queue_op(logic [MODE_W-1:0] op,
                                                    logic [PORT_PAY_W-1:0] pay,
                                                    logic [ALERT_W-1:0] alerts,
                                                    logic [TIME_W-1:0] ts);
        t_queue_reply     r;
        int               q;
        logic [PTR_W-1:0] head;
        r = '0;
        q = (op == MODE_PUSH_ALERT || op == MODE_PEEK_ALERT || op == MODE_COMMIT_ALERT)
            ? ALERT_Q : ROUTINE_Q;
        case (op)
            MODE_PUSH_ROUTINE, MODE_PUSH_ALERT: begin
                q_pay[q][q_wptr[q]]    = pay & PAY_MASK;
                q_alerts[q][q_wptr[q]] = alerts;
                q_tstamp[q][q_wptr[q]] = ts;
                q_wptr[q] = q_wptr[q] + 1'b1;
                // full queue: oldest entry is lost, count stays put
                if (q_fill[q] == QUEUE_DEPTH) begin
                    q_losses[q] = q_losses[q] + 1'b1;
                    n_overwrites++;
                end else begin
                    q_fill[q] = q_fill[q] + 1'b1;
                end
            end
            MODE_PEEK_ALERT, MODE_PEEK_ROUTINE: begin
                if (q_fill[q] != 0) begin
                    head      = q_wptr[q] - q_fill[q][PTR_W-1:0];
                    r.found   = 1'b1;
                    r.payload = q_pay[q][head];
                    r.alerts  = q_alerts[q][head];
                    r.tstamp  = q_tstamp[q][head];
                    n_peek_hits++;
                end else begin
                    n_peek_misses++;
                end
            end
            MODE_COMMIT_ALERT, MODE_COMMIT_ROUTINE: begin
                if (q_fill[q] != 0) q_fill[q] = q_fill[q] - 1'b1;
                else n_idle_commits++;
            end
            default: ;
        endcase
        r.alert_fill     = FILL_W'(q_fill[ALERT_Q]);
        r.routine_fill   = FILL_W'(q_fill[ROUTINE_Q]);
        r.alert_losses   = q_losses[ALERT_Q];
        r.routine_losses = q_losses[ROUTINE_Q];
        r.pending        = (q_fill[ALERT_Q] != 0) || (q_fill[ROUTINE_Q] != 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%0t ns mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) report_mismatch(what, want, got);
    endtask

    // Predict on every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            n_requests++;
            expected_replies.push_back(apply_queue_op(req_ch.mode, req_ch.payload,
                                                      req_ch.alert_flags, req_ch.timestamp));
        end
    end

    // Compare every accepted reply with the oldest prediction
    always @(posedge i_clk) begin : check_replies
        t_queue_reply want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            n_replies++;
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with no request outstanding", '0, '0);
            end else begin
                want = expected_replies.pop_front();
                check_field("found",          64'(want.found),   64'(rsp_ch.found));
                check_field("entry_payload",  64'(want.payload), 64'(rsp_ch.entry_payload));
                check_field("entry_alerts",   64'(want.alerts),  64'(rsp_ch.entry_alerts));
                check_field("entry_time",     64'(want.tstamp),  64'(rsp_ch.entry_time));
                check_field("alert_fill",     64'(want.alert_fill),
                            64'(rsp_ch.alert_fill));
                check_field("routine_fill",   64'(want.routine_fill),
                            64'(rsp_ch.routine_fill));
                check_field("alert_losses",   64'(want.alert_losses),
                            64'(rsp_ch.alert_losses));
                check_field("routine_losses", 64'(want.routine_losses),
                            64'(rsp_ch.routine_losses));
                check_field("pending",        64'(want.pending), 64'(rsp_ch.pending));
            end
        end
    end

    // Receiver: rotating stall mask, reselected from four patterns while stalls are on
    initial begin
        rsp_ch.ready = 1'b0;
        rx_mask      = 16'hFFFF;
        rx_phase     = 0;
        forever begin
            @(posedge i_clk);
            if (!rx_stall_on) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= rx_mask[0];
                rx_mask = {rx_mask[0], rx_mask[15:1]};
                rx_phase++;
                if (rx_phase == 48) begin
                    rx_phase = 0;
                    case ($urandom_range(0, 3))
                        0: rx_mask = 16'hFFFF;
                        1: rx_mask = 16'($urandom) | 16'h0001;
                        2: rx_mask = 16'($urandom & $urandom & $urandom) | 16'h0001;
                        default: rx_mask = 16'h00FF;
                    endcase
                end
            end
        end
    end

    function automatic logic [63:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Drive one request and hold it until taken; then maybe open a gap
    task automatic send_request(logic [MODE_W-1:0] op, logic [63:0] pay,
                                logic [7:0] alerts, logic [31:0] ts);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= op;
        req_ch.payload     <= pay;
        req_ch.alert_flags <= alerts;
        req_ch.timestamp   <= ts;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        if (tx_idle_on) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 5);
                if (gap > 0) begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // Status-only modes, peeks and commits on empty queues
    task automatic test_empty_status();
        send_request(MODE_UNUSED_LO, '1, 8'hFF, '1);
        send_request(MODE_UNUSED_HI, '0, 8'h00, '0);
        send_request(MODE_PEEK_ALERT, '1, 8'hFF, '1);
        send_request(MODE_PEEK_ROUTINE, '1, 8'hFF, '1);
        send_request(MODE_COMMIT_ALERT, '0, 8'h00, '0);
        send_request(MODE_COMMIT_ROUTINE, '0, 8'h00, '0);
    endtask

    // Field extremes through both queues, then drain past empty
    task automatic test_push_extremes();
        send_request(MODE_PUSH_ROUTINE, '1, 8'hFF, '1);
        send_request(MODE_PUSH_ROUTINE, '0, 8'h00, '0);
        send_request(MODE_PUSH_ALERT, 64'h8000_0000_0000_0001, 8'h80, 32'h8000_0001);
        send_request(MODE_PUSH_ALERT, '1, 8'h01, 32'hFFFF_FFFE);
        send_request(MODE_PEEK_ROUTINE, '0, 8'h00, '0);
        send_request(MODE_PEEK_ALERT, '0, 8'h00, '0);
        send_request(MODE_UNUSED_HI, '0, 8'h00, '0);
        send_request(MODE_COMMIT_ROUTINE, '0, 8'h00, '0);
        send_request(MODE_PEEK_ROUTINE, '1, 8'hFF, '1);
        send_request(MODE_COMMIT_ROUTINE, '0, 8'h00, '0);
        send_request(MODE_COMMIT_ROUTINE, '0, 8'h00, '0);
        send_request(MODE_COMMIT_ALERT, '0, 8'h00, '0);
        send_request(MODE_PEEK_ALERT, '0, 8'h00, '0);
        send_request(MODE_COMMIT_ALERT, '0, 8'h00, '0);
        send_request(MODE_COMMIT_ALERT, '0, 8'h00, '0);
    endtask

    // Overfill each queue a little, then peek/commit down to empty
    task automatic test_overflow();
        logic [MODE_W-1:0] push_op;
        logic [MODE_W-1:0] peek_op;
        logic [MODE_W-1:0] commit_op;
        int                n;
        for (int q = 0; q < 2; q++) begin
            push_op   = (q == ALERT_Q) ? MODE_PUSH_ALERT : MODE_PUSH_ROUTINE;
            peek_op   = (q == ALERT_Q) ? MODE_PEEK_ALERT : MODE_PEEK_ROUTINE;
            commit_op = (q == ALERT_Q) ? MODE_COMMIT_ALERT : MODE_COMMIT_ROUTINE;
            n = QUEUE_DEPTH + $urandom_range(1, 5);
            repeat (n) send_request(push_op, pick_payload(), 8'($urandom_range(0, 255)),
                                    pick_word());
            repeat (QUEUE_DEPTH + 1) begin
                send_request(peek_op, pick_payload(), 8'($urandom_range(0, 255)), pick_word());
                send_request(commit_op, pick_payload(), 8'($urandom_range(0, 255)),
                             pick_word());
            end
        end
    endtask

    // Overfill both queues back to back with the receiver always ready
    task automatic test_flat_overflow();
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        for (int i = 0; i < FLAT_PUSHES; i++) begin
            send_request(MODE_PUSH_ROUTINE, {$urandom, $urandom}, 8'($urandom), $urandom);
            send_request(MODE_PUSH_ALERT, {$urandom, $urandom}, 8'($urandom), $urandom);
        end
        send_request(MODE_PEEK_ROUTINE, '0, 8'h00, '0);
        send_request(MODE_PEEK_ALERT, '0, 8'h00, '0);
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // Segments with a random push bias so queues swing between empty and overfull
    task automatic test_random_mix();
        logic [MODE_W-1:0] op;
        int                done;
        int                seg_left;
        int                push_pct;
        int                r;
        done     = 0;
        seg_left = 0;
        push_pct = 50;
        while (done < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_left    = $urandom_range(30, 80);
                push_pct    = $urandom_range(10, 90);
                tx_idle_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                op = $urandom_range(0, 1) ? MODE_PUSH_ALERT : MODE_PUSH_ROUTINE;
            end else begin
                r = $urandom_range(0, 19);
                if (r < 9)       op = $urandom_range(0, 1) ? MODE_PEEK_ALERT : MODE_PEEK_ROUTINE;
                else if (r < 18) op = $urandom_range(0, 1) ? MODE_COMMIT_ALERT
                                                           : MODE_COMMIT_ROUTINE;
                else             op = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
            end
            send_request(op, pick_payload(), 8'($urandom_range(0, 255)), pick_word());
            if (op < MODE_UNUSED_LO) done++;
        end
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // Main sequence
    initial begin
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = '0;
        req_ch.payload     = '0;
        req_ch.alert_flags = '0;
        req_ch.timestamp   = '0;
        tx_idle_on         = 1'b1;
        burst_left         = 0;
        rx_stall_on        = 1'b1;
        mismatches         = 0;
        n_requests         = 0;
        n_replies          = 0;
        n_overwrites       = 0;
        n_peek_hits        = 0;
        n_peek_misses      = 0;
        n_idle_commits     = 0;
        for (int q = 0; q < 2; q++) begin
            q_wptr[q]   = '0;
            q_fill[q]   = '0;
            q_losses[q] = '0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_status();
        test_push_extremes();
        test_overflow();
        test_flat_overflow();
        test_random_mix();

        // Drain: wait out outstanding replies plus the pipeline depth
        req_ch.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_replies.size() != 0)
            report_mismatch("replies still outstanding", 64'(expected_replies.size()), '0);

        $display("covered %0d requests / %0d replies: %0d overwrites, %0d peek hits,",
                 n_requests, n_replies, n_overwrites, n_peek_hits);
        $display("%0d empty peeks, %0d empty commits, %0d mismatches",
                 n_peek_misses, n_idle_commits, mismatches);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
